[design/cone_workspace_clamp_core_macros.svh]
// assertion helpers for the cone clamp core
`ifndef CONE_WORKSPACE_CLAMP_CORE_MACROS_SVH
`define CONE_WORKSPACE_CLAMP_CORE_MACROS_SVH
`ifndef SYNTHESIS
// plain property check on the rising clock edge
`define CWC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cone clamp check failed");
// same-cycle implication check
`define CWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cone clamp implication failed");
`else
`define CWC_ASSERT(lbl, clk, rst_n, prop)
`define CWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

[design/cwc_pkg.sv]
package cwc_pkg;

  // default geometry of the coordinates
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // trig registers, Q1.15; the cosine carries an extra sign bit
  localparam int COS_W      = 17;
  localparam int SIN_W      = 16;
  localparam int TRIG_SHIFT = 15;
  localparam logic signed [COS_W-1:0] COS_RST = 17'sd23170;
  localparam logic [SIN_W-1:0]        SIN_RST = 16'd23170;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_APEX_HEIGHT = 2'd0,
    CFG_CONE_COS    = 2'd1,
    CFG_CONE_SIN    = 2'd2
  } cfg_idx_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_INSIDE    = 2'd0,
    ST_PROJECTED = 2'd1,
    ST_APEX      = 2'd2
  } status_e;

endpackage

[design/cwc_isqrt2.sv]
module cwc_isqrt2 #(
  parameter int RAD_W  = 66,
  parameter int SIDE_W = 1,
  localparam int ROOT_W = RAD_W / 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [RAD_W-1:0]  rad_a_i,
  input  logic [RAD_W-1:0]  rad_b_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_a_o,
  output logic [ROOT_W-1:0] root_b_o,
  output logic [SIDE_W-1:0] side_o
);

  // one root bit per stage, radicand consumed two bits at a time
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [ROOT_W:0]   rem;
    logic [ROOT_W-1:0] root;
  } lane_t;

  function automatic lane_t sq_step(lane_t cur);
    lane_t             nxt;
    logic [ROOT_W+2:0] acc;
    logic [ROOT_W+2:0] trial;
    acc      = {cur.rem, cur.rad[RAD_W-1 -: 2]};
    trial    = {1'b0, cur.root, 2'b01};
    nxt.rad  = {cur.rad[RAD_W-3:0], 2'b00};
    if (acc >= trial) begin
      nxt.rem  = (ROOT_W+1)'(acc - trial);
      nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = (ROOT_W+1)'(acc);
      nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  lane_t             a_q    [ROOT_W];
  lane_t             b_q    [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];
  logic              valid_q[ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    lane_t             a_prev;
    lane_t             b_prev;
    lane_t             a_d;
    lane_t             b_d;
    logic [SIDE_W-1:0] side_prev;
    logic              v_prev;

    // stage input: ports for the first stage, previous stage otherwise
    if (i == 0) begin : g_first
      assign a_prev    = '{rad: rad_a_i, rem: '0, root: '0};
      assign b_prev    = '{rad: rad_b_i, rem: '0, root: '0};
      assign side_prev = side_i;
      assign v_prev    = valid_i;
    end else begin : g_next
      assign a_prev    = a_q[i-1];
      assign b_prev    = b_q[i-1];
      assign side_prev = side_q[i-1];
      assign v_prev    = valid_q[i-1];
    end

    assign a_d = sq_step(a_prev);
    assign b_d = sq_step(b_prev);

    // valid travels with the beat
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else begin
        valid_q[i] <= v_prev;
      end
    end

    // payload registers
    always_ff @(posedge clk_i) begin
      a_q[i]    <= a_d;
      b_q[i]    <= b_d;
      side_q[i] <= side_prev;
    end
  end

  assign valid_o  = valid_q[ROOT_W-1];
  assign root_a_o = a_q[ROOT_W-1].root;
  assign root_b_o = b_q[ROOT_W-1].root;
  assign side_o   = side_q[ROOT_W-1];

endmodule

[design/cwc_div2.sv]
module cwc_div2 #(
  parameter int DIV_W  = 32,
  parameter int QUO_W  = 34,
  parameter int SIDE_W = 1,
  localparam int NUM_W = DIV_W + QUO_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_a_i,
  input  logic [NUM_W-1:0]  num_b_i,
  input  logic [DIV_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_a_o,
  output logic [QUO_W-1:0]  quo_b_o,
  output logic [SIDE_W-1:0] side_o
);

  // restoring division, one quotient bit per stage; low numerator bits
  // shift out of nq while quotient bits shift in
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] nq;
  } lane_t;

  function automatic lane_t div_step(lane_t cur, logic [DIV_W-1:0] den);
    lane_t          nxt;
    logic [DIV_W:0] acc;
    logic           ge;
    acc = {cur.rem, cur.nq[QUO_W-1]};
    ge  = (acc >= {1'b0, den});
    if (ge) begin
      nxt.rem = DIV_W'(acc - {1'b0, den});
    end else begin
      nxt.rem = DIV_W'(acc);
    end
    nxt.nq = {cur.nq[QUO_W-2:0], ge};
    return nxt;
  endfunction

  lane_t             a_q    [QUO_W];
  lane_t             b_q    [QUO_W];
  logic [DIV_W-1:0]  den_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];
  logic              valid_q[QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    lane_t             a_prev;
    lane_t             b_prev;
    lane_t             a_d;
    lane_t             b_d;
    logic [DIV_W-1:0]  den_prev;
    logic [SIDE_W-1:0] side_prev;
    logic              v_prev;

    // stage input: ports for the first stage, previous stage otherwise
    if (i == 0) begin : g_first
      assign a_prev    = '{rem: num_a_i[NUM_W-1:QUO_W], nq: num_a_i[QUO_W-1:0]};
      assign b_prev    = '{rem: num_b_i[NUM_W-1:QUO_W], nq: num_b_i[QUO_W-1:0]};
      assign den_prev  = den_i;
      assign side_prev = side_i;
      assign v_prev    = valid_i;
    end else begin : g_next
      assign a_prev    = a_q[i-1];
      assign b_prev    = b_q[i-1];
      assign den_prev  = den_q[i-1];
      assign side_prev = side_q[i-1];
      assign v_prev    = valid_q[i-1];
    end

    assign a_d = div_step(a_prev, den_prev);
    assign b_d = div_step(b_prev, den_prev);

    // valid travels with the beat
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else begin
        valid_q[i] <= v_prev;
      end
    end

    // payload registers
    always_ff @(posedge clk_i) begin
      a_q[i]    <= a_d;
      b_q[i]    <= b_d;
      den_q[i]  <= den_prev;
      side_q[i] <= side_prev;
    end
  end

  assign valid_o = valid_q[QUO_W-1];
  assign quo_a_o = a_q[QUO_W-1].nq;
  assign quo_b_o = b_q[QUO_W-1].nq;
  assign side_o  = side_q[QUO_W-1];

endmodule

[design/cone_workspace_clamp_core.sv]
// channel  dir  handshake                  payload
// item     in   start high, busy low       point_x_i, point_y_i, point_z_i
// result   out  out_valid_o, one cycle     out_x_o, out_y_o, out_z_o, status_o
// config   in   cfg_valid_i & cfg_ready_o  cfg_idx_i, cfg_data_i
//
// one item per cycle; busy stays low and cfg_ready_o stays high
// the pipeline runs through local stages, the bit-serial square root
// (COORD_WIDTH+1 stages) and the divider (COORD_WIDTH+2 stages)
// reset clears the valid line and loads the register defaults
// results are strobed once and are never held; nothing inside can stall

`include "cone_workspace_clamp_core_macros.svh"

module cone_workspace_clamp_core #(
  parameter int COORD_WIDTH = cwc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = cwc_pkg::FRAC_BITS_DEF,
  localparam int CfgDw = (COORD_WIDTH > cwc_pkg::COS_W) ? COORD_WIDTH : cwc_pkg::COS_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  output logic                          out_valid_o,
  output logic signed [COORD_WIDTH-1:0] out_x_o,
  output logic signed [COORD_WIDTH-1:0] out_y_o,
  output logic signed [COORD_WIDTH-1:0] out_z_o,
  output logic [1:0]                    status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cwc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CfgDw-1:0]              cfg_data_i
);
  import cwc_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int W2    = 2 * W;
  localparam int H     = W / 2;
  localparam int RadW  = W2 + 2;
  localparam int RootW = RadW / 2;
  localparam int QuoW  = W + 2;
  localparam int ML    = QuoW / 2;
  localparam int NumW  = W + QuoW;
  localparam int PsW   = RootW + SIN_W;
  localparam int PcW   = RootW + COS_W;
  localparam int ZmW   = PcW - TRIG_SHIFT;
  localparam int VW    = ((W > FRAC_BITS + 1) ? W : FRAC_BITS + 1) + 4;

  typedef struct packed {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] z;
    logic [W-1:0]        ax;
    logic [W-1:0]        ay;
    logic [W-1:0]        adz;
    logic                dz_neg;
    logic                apex;
  } sq_side_t;

  typedef struct packed {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] z;
    logic [QuoW-1:0]     m;
    logic [ZmW-1:0]      zmag;
    logic                proj;
    logic                apex;
    logic                r_zero;
  } dv_side_t;

  // saturate a wide signed value to the coordinate width
  function automatic logic [W-1:0] sat_w(logic signed [VW-1:0] v);
    logic [VW-W:0] top_bits;
    top_bits = v[VW-1:W-1];
    if (&top_bits || !(|top_bits)) begin
      return v[W-1:0];
    end else if (v[VW-1]) begin
      return {1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  logic accept;
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // configuration registers
  logic signed [W-1:0]     apex_q;
  logic signed [COS_W-1:0] cos_q;
  logic [SIN_W-1:0]        sin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      apex_q <= '0;
      cos_q  <= COS_RST;
      sin_q  <= SIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_i)
        CFG_APEX_HEIGHT: apex_q <= cfg_data_i[W-1:0];
        CFG_CONE_COS:    cos_q  <= cfg_data_i[COS_W-1:0];
        CFG_CONE_SIN:    sin_q  <= cfg_data_i[SIN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [COS_W-1:0] cos_mag;
  logic             cos_pos;
  assign cos_mag = cos_q[COS_W-1] ? COS_W'(-cos_q) : cos_q;
  assign cos_pos = !cos_q[COS_W-1] && (cos_q != '0);

  // valid line of the local stages
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
  logic sq_valid, dv_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      v8_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      v1_q        <= accept;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= sq_valid;
      v6_q        <= v5_q;
      v7_q        <= v6_q;
      v8_q        <= v7_q;
      out_valid_o <= dv_valid;
    end
  end

  // stage 1: capture the beat and the offset from the apex
  logic signed [W-1:0] x1_q, y1_q, z1_q;
  logic signed [W:0]   dz1_q;

  always_ff @(posedge clk_i) begin
    x1_q  <= point_x_i;
    y1_q  <= point_y_i;
    z1_q  <= point_z_i;
    dz1_q <= (W+1)'(point_z_i) - (W+1)'(apex_q);
  end

  // stage 2: magnitudes and the apex test
  sq_side_t s2_q;

  always_ff @(posedge clk_i) begin
    s2_q.x      <= x1_q;
    s2_q.y      <= y1_q;
    s2_q.z      <= z1_q;
    s2_q.ax     <= x1_q[W-1] ? W'(-x1_q) : W'(x1_q);
    s2_q.ay     <= y1_q[W-1] ? W'(-y1_q) : W'(y1_q);
    s2_q.adz    <= dz1_q[W] ? W'(-dz1_q) : W'(dz1_q);
    s2_q.dz_neg <= dz1_q[W];
    s2_q.apex   <= (x1_q == '0) && (y1_q == '0) && (dz1_q == '0);
  end

  // stage 3: squares as half-width partial products
  sq_side_t           s3_q;
  logic [W+H-1:0]     pxl_q, pyl_q, pzl_q;
  logic [W2-H-1:0]    pxh_q, pyh_q, pzh_q;

  always_ff @(posedge clk_i) begin
    s3_q  <= s2_q;
    pxl_q <= s2_q.ax * s2_q.ax[H-1:0];
    pxh_q <= s2_q.ax * s2_q.ax[W-1:H];
    pyl_q <= s2_q.ay * s2_q.ay[H-1:0];
    pyh_q <= s2_q.ay * s2_q.ay[W-1:H];
    pzl_q <= s2_q.adz * s2_q.adz[H-1:0];
    pzh_q <= s2_q.adz * s2_q.adz[W-1:H];
  end

  // stage 4: planar and full squared length
  sq_side_t    s4_q;
  logic [W2-1:0] sxy_q;
  logic [W2:0]   s_q;
  logic [W2-1:0] sqx, sqy, sqz, sxy_d;

  assign sqx   = W2'(pxl_q) + {pxh_q, {H{1'b0}}};
  assign sqy   = W2'(pyl_q) + {pyh_q, {H{1'b0}}};
  assign sqz   = W2'(pzl_q) + {pzh_q, {H{1'b0}}};
  assign sxy_d = sqx + sqy;

  always_ff @(posedge clk_i) begin
    s4_q  <= s3_q;
    sxy_q <= sxy_d;
    s_q   <= (W2+1)'(sxy_d) + (W2+1)'(sqz);
  end

  // both roots in lockstep: d of the full length, r of the planar length
  sq_side_t         sq_side;
  logic [RootW-1:0] root_d, root_r;

  cwc_isqrt2 #(
    .RAD_W  (RadW),
    .SIDE_W ($bits(sq_side_t))
  ) u_isqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v4_q),
    .rad_a_i  (RadW'(s_q)),
    .rad_b_i  (RadW'(sxy_q)),
    .side_i   (s4_q),
    .valid_o  (sq_valid),
    .root_a_o (root_d),
    .root_b_o (root_r),
    .side_o   (sq_side)
  );

  // stage 5: scale d by sine and cosine
  sq_side_t      s5_q;
  logic [PsW-1:0] psin_q;
  logic [PcW-1:0] pcos_q;
  logic [W-1:0]   r5_q;

  always_ff @(posedge clk_i) begin
    s5_q   <= sq_side;
    psin_q <= root_d * sin_q;
    pcos_q <= root_d * cos_mag;
    r5_q   <= root_r[W-1:0];
  end

  // stage 6: cone test, new planar length and z offset
  sq_side_t       s6_q;
  logic [QuoW-1:0] m6_q;
  logic [ZmW-1:0]  zmag6_q;
  logic            proj6_q;
  logic [W-1:0]    r6_q;

  always_ff @(posedge clk_i) begin
    s6_q    <= s5_q;
    m6_q    <= psin_q[PsW-1:TRIG_SHIFT];
    zmag6_q <= pcos_q[PcW-1:TRIG_SHIFT];
    proj6_q <= s5_q.dz_neg ||
               (cos_pos && (PcW'({s5_q.adz, {TRIG_SHIFT{1'b0}}}) < pcos_q));
    r6_q    <= r5_q;
  end

  // stage 7: |x|*m and |y|*m as half-width partial products
  dv_side_t           d7_q;
  logic [W+ML-1:0]    nxl_q, nyl_q;
  logic [NumW-ML-1:0] nxh_q, nyh_q;
  logic [W-1:0]       r7_q;

  always_ff @(posedge clk_i) begin
    d7_q.x      <= s6_q.x;
    d7_q.y      <= s6_q.y;
    d7_q.z      <= s6_q.z;
    d7_q.m      <= m6_q;
    d7_q.zmag   <= zmag6_q;
    d7_q.proj   <= proj6_q;
    d7_q.apex   <= s6_q.apex;
    d7_q.r_zero <= (r6_q == '0);
    nxl_q       <= s6_q.ax * m6_q[ML-1:0];
    nxh_q       <= s6_q.ax * m6_q[QuoW-1:ML];
    nyl_q       <= s6_q.ay * m6_q[ML-1:0];
    nyh_q       <= s6_q.ay * m6_q[QuoW-1:ML];
    r7_q        <= r6_q;
  end

  // stage 8: divider numerators
  dv_side_t        d8_q;
  logic [NumW-1:0] nx8_q, ny8_q;
  logic [W-1:0]    r8_q;

  always_ff @(posedge clk_i) begin
    d8_q  <= d7_q;
    nx8_q <= NumW'(nxl_q) + {nxh_q, {ML{1'b0}}};
    ny8_q <= NumW'(nyl_q) + {nyh_q, {ML{1'b0}}};
    r8_q  <= r7_q;
  end

  // x and y share the planar length as divisor
  dv_side_t        dv_side;
  logic [QuoW-1:0] qx, qy;

  cwc_div2 #(
    .DIV_W  (W),
    .QUO_W  (QuoW),
    .SIDE_W ($bits(dv_side_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v8_q),
    .num_a_i (nx8_q),
    .num_b_i (ny8_q),
    .den_i   (r8_q),
    .side_i  (d8_q),
    .valid_o (dv_valid),
    .quo_a_o (qx),
    .quo_b_o (qy),
    .side_o  (dv_side)
  );

  // output stage: pick the case, restore signs, saturate
  logic signed [VW-1:0] one_v, apex_v, qx_v, qy_v, m_v, zm_v;
  logic signed [VW-1:0] px_v, py_v, pz_v, az_v;
  logic [W-1:0]         ox_d, oy_d, oz_d;
  status_e              st_d;

  assign one_v  = {{(VW-1){1'b0}}, 1'b1} << FRAC_BITS;
  assign apex_v = VW'(apex_q);
  assign qx_v   = VW'(qx);
  assign qy_v   = VW'(qy);
  assign m_v    = VW'(dv_side.m);
  assign zm_v   = VW'(dv_side.zmag);
  assign px_v   = dv_side.r_zero ? m_v : (dv_side.x[W-1] ? -qx_v : qx_v);
  assign py_v   = dv_side.r_zero ? '0 : (dv_side.y[W-1] ? -qy_v : qy_v);
  assign pz_v   = apex_v + (cos_q[COS_W-1] ? -zm_v : zm_v);
  assign az_v   = apex_v + one_v;

  always_comb begin
    priority if (dv_side.apex) begin
      ox_d = '0;
      oy_d = '0;
      oz_d = sat_w(az_v);
      st_d = ST_APEX;
    end else if (!dv_side.proj) begin
      ox_d = dv_side.x;
      oy_d = dv_side.y;
      oz_d = dv_side.z;
      st_d = ST_INSIDE;
    end else begin
      ox_d = sat_w(px_v);
      oy_d = sat_w(py_v);
      oz_d = sat_w(pz_v);
      st_d = ST_PROJECTED;
    end
  end

  status_e status_q;

  always_ff @(posedge clk_i) begin
    out_x_o  <= ox_d;
    out_y_o  <= oy_d;
    out_z_o  <= oz_d;
    status_q <= st_d;
  end

  assign status_o = status_q;

  // apex results sit on the axis
  `CWC_ASSERT_IMP(a_apex_on_axis, clk_i, rst_ni, out_valid_o && status_o == ST_APEX, out_x_o == '0 && out_y_o == '0)
  // a zero sine collapses the projected point onto the axis
  `CWC_ASSERT_IMP(a_zero_sine_axis, clk_i, rst_ni, out_valid_o && status_o == ST_PROJECTED && sin_q == '0, out_x_o == '0 && out_y_o == '0)
  // points that pass unchanged never lie below the apex
  `CWC_ASSERT(a_inside_above_apex, clk_i, rst_ni, !(out_valid_o && status_o == ST_INSIDE) || out_z_o >= apex_q)

endmodule
